>>> hw/rtl/weighted_grid_cell_sampler_macros.svh
// Assertion macros shared by the weighted grid cell sampler RTL.
`ifndef WEIGHTED_GRID_CELL_SAMPLER_MACROS_SVH
`define WEIGHTED_GRID_CELL_SAMPLER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define WGCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define WGCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WGCS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WGCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/wgcs_pkg.sv
// Shared types, codes and helper functions of the weighted grid cell sampler.
`timescale 1ns / 1ps
`default_nettype none
package wgcs_pkg;

    localparam int MAX_CELLS_DEF = 4096;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_DRAW    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PARTIAL = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    localparam logic [2:0] REG_GRID_WIDTH   = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_NARROW_RATIO = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd4;
    localparam logic [2:0] REG_CELL_SIZE    = 3'd5;

    localparam logic signed [29:0] W25_MAX = 30'sd16777215;
    localparam logic signed [29:0] W25_MIN = -30'sd16777216;

    typedef struct packed {
        logic load;
        logic restart;
        logic draw;
        logic mul_target;
        logic probe;
        logic compare;
        logic div_start;
        logic div_step;
        logic mul_x;
        logic mul_y;
        logic out_load;
    } wgcs_cmd_t;

    typedef struct packed {
        logic early;
        logic search_busy;
        logic div_done;
        logic out_free;
    } wgcs_stat_t;

    // Clamp a grid dimension to 1..4096.
    function automatic logic [12:0] dim_clamp(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > 13'd4096) begin
            r = 13'd4096;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Origin plus cell offset, saturated to the signed 25 bit range.
    function automatic logic [24:0] world_sat(input logic signed [23:0] org,
                                              input logic [27:0] off);
        logic signed [29:0] s;
        logic [24:0] r;
        s = $signed({{6{org[23]}}, org}) + $signed({2'b00, off});
        if (s > W25_MAX) begin
            r = 25'h0FFFFFF;
        end else if (s < W25_MIN) begin
            r = 25'h1000000;
        end else begin
            r = s[24:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/wgcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wgcs_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = wgcs_pkg::MAX_CELLS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/wgcs_dp.sv
// Datapath: configuration, cumulative table, search, divider, coordinates, output word.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_grid_cell_sampler_macros.svh"
module wgcs_dp #(
    parameter int MAX_CELLS = wgcs_pkg::MAX_CELLS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wgcs_pkg::wgcs_cmd_t ctl,
    output wgcs_pkg::wgcs_stat_t    sts,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic [12:0]        passage_value,
    input  wire logic [15:0]        random_fraction,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic                    uniform_turn,
    output logic [1:0]              status,
    output logic [11:0]             cell_column,
    output logic [11:0]             cell_row,
    output logic signed [24:0]      world_x,
    output logic signed [24:0]      world_y
);
    import wgcs_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);
    localparam int PW = $clog2(MAX_CELLS + 1);
    localparam int CW = $clog2(AW + 1);

    logic [12:0]        gw_reg, gh_reg;
    logic signed [8:0]  ratio_reg;
    logic signed [23:0] ox_reg, oy_reg;
    logic [15:0]        csize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg    <= 13'd64;
            gh_reg    <= 13'd64;
            ratio_reg <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            csize_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:   gw_reg    <= cfg_data[12:0];
                REG_GRID_HEIGHT:  gh_reg    <= cfg_data[12:0];
                REG_NARROW_RATIO: ratio_reg <= cfg_data[8:0];
                REG_ORIGIN_X:     ox_reg    <= cfg_data;
                REG_ORIGIN_Y:     oy_reg    <= cfg_data;
                REG_CELL_SIZE:    csize_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Grid geometry
    logic [12:0] w, h, m, wt;
    logic [25:0] cells_full;
    logic [24:0] cells, lim;
    assign w          = dim_clamp(gw_reg);
    assign h          = dim_clamp(gh_reg);
    assign m          = (w < h) ? w : h;
    assign wt         = (passage_value < m) ? (m - passage_value) : 13'd0;
    assign cells_full = {13'd0, w} * {13'd0, h};
    assign cells      = cells_full[24:0];
    assign lim        = (cells < 25'(MAX_CELLS)) ? cells : 25'(MAX_CELLS);

    // Table load
    logic [PW-1:0] ptr_reg;
    logic [24:0]   total_reg, total_sat;
    logic [25:0]   sum26;
    logic          can_load, ram_we;
    assign can_load  = 25'(ptr_reg) < lim;
    assign ram_we    = ctl.load & can_load;
    assign sum26     = {1'b0, total_reg} + 26'(wt);
    assign total_sat = sum26[25] ? 25'h1FFFFFF : sum26[24:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            total_reg <= '0;
        end
        else if (ctl.restart)
        begin
            ptr_reg   <= '0;
            total_reg <= '0;
        end
        else if (ram_we)
        begin
            ptr_reg   <= ptr_reg + 1'b1;
            total_reg <= total_sat;
        end
    end

    // Interleave decision
    logic [8:0] icnt_reg, icnt_next;
    logic [7:0] mag;
    logic       pos, uniform;
    assign pos = (ratio_reg > 9'sd0);
    assign mag = (ratio_reg == -9'sd256) ? 8'd255 : 8'(-ratio_reg);
    always_comb
    begin
        if (pos)
        begin
            uniform   = icnt_reg >= {1'b0, ratio_reg[7:0]};
            icnt_next = uniform ? 9'd0 : icnt_reg + 1'b1;
        end
        else
        begin
            uniform   = icnt_reg < {1'b0, mag};
            icnt_next = uniform ? icnt_reg + 1'b1 : 9'd0;
        end
    end

    logic       partial, zero_tot;
    logic       early_reg, uni_reg;
    logic [1:0] stat_reg;
    logic [15:0] rnd_reg;
    assign partial  = 25'(ptr_reg) != cells;
    assign zero_tot = (total_reg == 25'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icnt_reg  <= '0;
            early_reg <= 1'b0;
            uni_reg   <= 1'b0;
            stat_reg  <= ST_OK;
        end
        else if (ctl.draw)
        begin
            icnt_reg  <= icnt_next;
            uni_reg   <= uniform;
            early_reg <= uniform | partial | zero_tot;
            if (uniform)
            begin
                stat_reg <= ST_OK;
            end
            else if (partial)
            begin
                stat_reg <= ST_PARTIAL;
            end
            else if (zero_tot)
            begin
                stat_reg <= ST_ZERO;
            end
            else
            begin
                stat_reg <= ST_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.draw)
        begin
            rnd_reg <= random_fraction;
        end
    end

    // Binary search over the cumulative table
    logic [40:0]   tgt_reg, tgt_prod;
    logic [AW-1:0] lo_reg, hi_reg, mid;
    logic [AW:0]   mid_sum;
    logic [24:0]   rdata;
    logic          ge;
    assign tgt_prod = rnd_reg * total_reg;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[AW:1];
    assign ge       = {rdata, 16'd0} >= tgt_reg;

    wgcs_ram #(.WIDTH(25), .DEPTH(MAX_CELLS)) u_cum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg[AW-1:0]),
        .wdata (total_sat),
        .re    (ctl.probe),
        .raddr (mid),
        .rdata (rdata)
    );

    // Divider: index / width, one quotient bit per cycle
    logic [AW-1:0] q_reg;
    logic [12:0]   rem_reg, rem_sh;
    logic [CW-1:0] dcnt_reg;
    logic          dge;
    assign rem_sh = {rem_reg[11:0], q_reg[AW-1]};
    assign dge    = rem_sh >= w;

    // Coordinate multiplier, shared by x and y
    logic [28:0] prod_reg, prod_next;
    logic [11:0] mop;
    logic [24:0] wx_reg;
    assign mop       = ctl.mul_x ? rem_reg[11:0] : 12'(q_reg);
    assign prod_next = {mop, 1'b1} * csize_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_target)
        begin
            tgt_reg <= tgt_prod;
            lo_reg  <= '0;
            hi_reg  <= AW'(ptr_reg - 1'b1);
        end
        else if (ctl.compare)
        begin
            if (ge)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + 1'b1;
            end
        end
        if (ctl.div_start)
        begin
            q_reg    <= lo_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            q_reg    <= {q_reg[AW-2:0], dge};
            rem_reg  <= dge ? (rem_sh - w) : rem_sh;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (ctl.mul_x || ctl.mul_y)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.mul_y)
        begin
            wx_reg <= world_sat(ox_reg, prod_reg[28:1]);
        end
    end

    // Output word
    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            uniform_turn <= uni_reg;
            status       <= stat_reg;
            cell_column  <= early_reg ? 12'd0 : rem_reg[11:0];
            cell_row     <= early_reg ? 12'd0 : 12'(q_reg);
            world_x      <= early_reg ? 25'd0 : wx_reg;
            world_y      <= early_reg ? 25'd0 : world_sat(oy_reg, prod_reg[28:1]);
        end
    end

    assign out_valid       = out_valid_reg;
    assign sts.early       = early_reg;
    assign sts.search_busy = lo_reg < hi_reg;
    assign sts.div_done    = (dcnt_reg == CW'(AW));
    assign sts.out_free    = !out_valid_reg || out_ready;

    `WGCS_ASSERT_NOW(a_cmp_range, clk, rst_n, ctl.compare, lo_reg < hi_reg)
    `WGCS_ASSERT_NOW(a_we_bound, clk, rst_n, ram_we, ptr_reg < PW'(MAX_CELLS))
    `WGCS_ASSERT_NOW(a_search_ok, clk, rst_n, ctl.mul_target, !early_reg)
endmodule
`default_nettype wire

>>> hw/rtl/wgcs_ctrl.sv
// Controller state machine sequencing loads and draws.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_grid_cell_sampler_macros.svh"
module wgcs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           cmd,
    input  wire wgcs_pkg::wgcs_stat_t sts,
    output wgcs_pkg::wgcs_cmd_t       ctl
);
    import wgcs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TGT   = 4'd1;
    localparam logic [3:0] S_PROBE = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_MX    = 4'd5;
    localparam logic [3:0] S_MY    = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.load    = accept && (cmd == CMD_LOAD);
                ctl.restart = accept && (cmd == CMD_RESTART);
                ctl.draw    = accept && (cmd == CMD_DRAW);
                if (ctl.draw)
                begin
                    state_next = S_TGT;
                end
            end
            S_TGT:
            begin
                if (sts.early)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.mul_target = 1'b1;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.search_busy)
                begin
                    ctl.probe  = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_CMP:
            begin
                ctl.compare = 1'b1;
                state_next  = S_PROBE;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_MX;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            S_MX:
            begin
                ctl.mul_x  = 1'b1;
                state_next = S_MY;
            end
            S_MY:
            begin
                ctl.mul_y  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `WGCS_ASSERT_NEXT(a_probe_cmp, clk, rst_n, ctl.probe, state_reg == S_CMP)
    `WGCS_ASSERT_NOW(a_out_free, clk, rst_n, ctl.out_load, sts.out_free)
    `WGCS_ASSERT_NEXT(a_div_start, clk, rst_n, ctl.div_start, state_reg == S_DIV)
endmodule
`default_nettype wire

>>> hw/rtl/weighted_grid_cell_sampler.sv
// Top level of the weighted grid cell sampler: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Inverse-CDF sampler over a grid of cells. Load cells in row-major order
// (cmd 0, one word per cell, one per cycle while idle); each passage value
// p becomes weight max(M-p,0), M = min(width,height), and its saturating
// running sum goes into a cumulative table RAM of MAX_CELLS entries. A draw
// (cmd 1) takes a Q0.16 fraction and returns one output word: the first
// cell whose sum*65536 reaches R*total, its row/column and its centre in
// signed Q.8. Turns given to uniform sampling, an incomplete table and a
// zero total come back without a search, with zeroed cell fields. A full
// draw runs a binary search, probing the table RAM with its registered
// read, then the index/width divider at one quotient bit per cycle, then
// the shared coordinate multiplier for x and y. One word is worked on at
// a time; the output register lets the next load be taken while a result
// waits. Restart (cmd 2) clears the load pointer and total; cmd 3 is
// ignored. Configuration writes are taken every cycle and belong in idle
// periods.
module weighted_grid_cell_sampler #(
    parameter int MAX_CELLS = wgcs_pkg::MAX_CELLS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         cmd,
    input  wire logic [12:0]        passage_value,
    input  wire logic [15:0]        random_fraction,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    uniform_turn,
    output logic [1:0]              status,
    output logic [11:0]             cell_column,
    output logic [11:0]             cell_row,
    output logic signed [24:0]      world_x,
    output logic signed [24:0]      world_y
);
    import wgcs_pkg::*;

    wgcs_cmd_t  ctl;
    wgcs_stat_t sts;
    logic       cfg_we;

    // Registers accept a write in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    wgcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    wgcs_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .passage_value   (passage_value),
        .random_fraction (random_fraction),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .uniform_turn    (uniform_turn),
        .status          (status),
        .cell_column     (cell_column),
        .cell_row        (cell_row),
        .world_x         (world_x),
        .world_y         (world_y)
    );
endmodule
`default_nettype wire

>>> verif/weighted_grid_cell_sampler_test.sv
// Self-checking testbench for the weighted grid cell sampler.
`timescale 1ns / 1ps
`default_nettype none
module weighted_grid_cell_sampler_test;
    import wgcs_pkg::*;

    // One input word as the driver sees it
    typedef struct packed {
        logic [1:0]  op;
        logic [12:0] pv;
        logic [15:0] frac;
    } cmd_word_t;

    // One expected result word
    typedef struct packed {
        logic        uni;
        logic [1:0]  st;
        logic [11:0] col;
        logic [11:0] row;
        logic [24:0] wx;
        logic [24:0] wy;
    } sample_t;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] cmd;
    logic [12:0] passage_value;
    logic [15:0] random_fraction;
    logic out_valid;
    logic out_ready;
    logic uniform_turn;
    logic [1:0] status;
    logic [11:0] cell_column;
    logic [11:0] cell_row;
    logic signed [24:0] world_x;
    logic signed [24:0] world_y;

    weighted_grid_cell_sampler DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .passage_value(passage_value), .random_fraction(random_fraction),
        .out_valid(out_valid), .out_ready(out_ready),
        .uniform_turn(uniform_turn), .status(status),
        .cell_column(cell_column), .cell_row(cell_row),
        .world_x(world_x), .world_y(world_y)
    );

    // Predictor copy of configuration and sampler state
    logic [12:0] grid_w_reg, grid_h_reg;
    logic [8:0]  ratio_reg;
    logic [23:0] org_x_reg, org_y_reg;
    logic [15:0] size_reg;
    logic [24:0] cum_sums [0:4095];
    int unsigned fill_ptr;
    int unsigned weight_total;
    int          turn_count;

    cmd_word_t pending_words[$];
    sample_t   expected_samples[$];
    int        errors;
    int        idle_pct;      // chance per cycle of idling on either side
    int        stall_cycles;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned eff_dim(input logic [12:0] v);
        if (v == 13'd0) return 1;
        if (v > 13'd4096) return 4096;
        return v;
    endfunction

    function automatic logic [24:0] cell_centre(input logic [23:0] org, input int unsigned idx);
        longint off;
        longint v;
        off = ((longint'(idx) * 2 + 1) * longint'(size_reg)) >>> 1;
        v = longint'($signed(org)) + off;
        if (v > 16777215) v = 16777215;
        if (v < -16777216) v = -16777216;
        return v[24:0];
    endfunction

    // Advance the predictor by one accepted word; push a sample for draws
    task automatic predict_word(input cmd_word_t w);
        int unsigned gw, gh, cells, lim, m, wt, lo, hi, mid, idx;
        int ratio;
        bit uni;
        longint unsigned target;
        sample_t s;
        gw = eff_dim(grid_w_reg);
        gh = eff_dim(grid_h_reg);
        cells = gw * gh;
        case (w.op)
            CMD_LOAD:
            begin
                lim = cells < 4096 ? cells : 4096;
                m = gw < gh ? gw : gh;
                wt = w.pv < m ? m - w.pv : 0;
                if (fill_ptr < lim)
                begin
                    weight_total = weight_total + wt;
                    if (weight_total > 32'h1FFFFFF) weight_total = 32'h1FFFFFF;
                    cum_sums[fill_ptr] = 25'(weight_total);
                    fill_ptr++;
                end
            end
            CMD_RESTART:
            begin
                fill_ptr = 0;
                weight_total = 0;
            end
            CMD_DRAW:
            begin
                ratio = $signed(ratio_reg);
                if (ratio < -255) ratio = -255;
                uni = ratio > 0 ? !(turn_count < ratio) : (turn_count < -ratio);
                if (uni == (ratio > 0)) turn_count = 0;
                else turn_count++;
                s = '0;
                if (uni) s.uni = 1'b1;
                else if (fill_ptr != cells) s.st = ST_PARTIAL;
                else if (weight_total == 0) s.st = ST_ZERO;
                else
                begin
                    target = longint'(w.frac) * weight_total;
                    lo = 0;
                    hi = fill_ptr - 1;
                    while (lo < hi)
                    begin
                        mid = lo + ((hi - lo) >> 1);
                        if ((longint'(cum_sums[mid]) << 16) >= target) hi = mid;
                        else lo = mid + 1;
                    end
                    idx = lo;
                    s.col = 12'(idx % gw);
                    s.row = 12'(idx / gw);
                    s.wx = cell_centre(org_x_reg, idx % gw);
                    s.wy = cell_centre(org_y_reg, idx / gw);
                end
                expected_samples.push_back(s);
            end
            default: ;
        endcase
    endtask

    // Driver: hold a word until accepted, idle at random between words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_LOAD;
            passage_value <= '0;
            random_fraction <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_word({cmd, passage_value, random_fraction});
            if ((!in_valid || in_ready) && pending_words.size() > 0
                && $urandom_range(99) >= idle_pct)
            begin
                cmd_word_t w;
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                cmd <= w.op;
                passage_value <= w.pv;
                random_fraction <= w.frac;
            end
            else if (in_valid && in_ready)
                in_valid <= 1'b0;
        end
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                sample_t e;
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h", $time,
                             {uniform_turn, status, cell_column, cell_row, world_x, world_y});
                    errors++;
                end
                else
                begin
                    e = expected_samples.pop_front();
                    if (uniform_turn !== e.uni)
                    begin
                        $display("%0t: uniform_turn expected %0d actual %0d", $time,
                                 e.uni, uniform_turn);
                        errors++;
                    end
                    if (status !== e.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.st, status);
                        errors++;
                    end
                    if (cell_column !== e.col)
                    begin
                        $display("%0t: cell_column expected %0d actual %0d", $time,
                                 e.col, cell_column);
                        errors++;
                    end
                    if (cell_row !== e.row)
                    begin
                        $display("%0t: cell_row expected %0d actual %0d", $time,
                                 e.row, cell_row);
                        errors++;
                    end
                    if (world_x !== e.wx)
                    begin
                        $display("%0t: world_x expected %0d actual %0d", $time,
                                 $signed(e.wx), world_x);
                        errors++;
                    end
                    if (world_y !== e.wy)
                    begin
                        $display("%0t: world_y expected %0d actual %0d", $time,
                                 $signed(e.wy), world_y);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: count cycles with no accepted word on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("weighted_grid_cell_sampler_test: done, errors");
            $finish;
        end
    end

    // Write one register while idle and mirror it in the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:   grid_w_reg = val[12:0];
            REG_GRID_HEIGHT:  grid_h_reg = val[12:0];
            REG_NARROW_RATIO: ratio_reg = val[8:0];
            REG_ORIGIN_X:     org_x_reg = val;
            REG_ORIGIN_Y:     org_y_reg = val;
            REG_CELL_SIZE:    size_reg = val[15:0];
            default: ;
        endcase
    endtask

    // Wait for every queued word and result to drain, then let the block settle
    task automatic drain();
        wait (pending_words.size() == 0 && !in_valid && expected_samples.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic push_word(input logic [1:0] op, input int pv, input int fr);
        cmd_word_t w;
        w.op = op;
        w.pv = 13'(pv);
        w.frac = 16'(fr);
        pending_words.push_back(w);
    endtask

    // Restart and load a full table; mostly small passage values
    task automatic load_table(input int unsigned cells, input int mode);
        push_word(CMD_RESTART, $urandom, $urandom);
        for (int unsigned i = 0; i < cells; i++)
        begin
            case (mode)
                0: push_word(CMD_LOAD, $urandom_range(8), 0);
                1: push_word(CMD_LOAD, 13'h1FFF, 0);
                default: push_word(CMD_LOAD, $urandom, $urandom);
            endcase
        end
    endtask

    task automatic set_grid(input int gw, input int gh);
        write_reg(REG_GRID_WIDTH, 24'(gw));
        write_reg(REG_GRID_HEIGHT, 24'(gh));
    endtask

    int sent;
    int gw, gh, ph, r;

    initial begin
        errors = 0;
        idle_pct = 28;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data = '0;
        grid_w_reg = 13'd64;
        grid_h_reg = 13'd64;
        ratio_reg = '0;
        org_x_reg = '0;
        org_y_reg = '0;
        size_reg = 16'd256;
        fill_ptr = 0;
        weight_total = 0;
        turn_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a draw before loading, unused command, tiny grid extremes
        push_word(CMD_DRAW, 0, 16'hFFFF);
        push_word(2'd3, 13'h1FFF, 16'hFFFF);
        drain();
        set_grid(2, 2);
        write_reg(REG_ORIGIN_X, 24'h7FFFFF);
        write_reg(REG_ORIGIN_Y, 24'h800000);
        write_reg(REG_CELL_SIZE, 24'hFFFF);
        push_word(CMD_RESTART, 0, 0);
        push_word(CMD_LOAD, 0, 0);
        push_word(CMD_LOAD, 4096, 0);
        push_word(CMD_LOAD, 1, 0);
        push_word(CMD_LOAD, 2, 0);
        push_word(CMD_LOAD, 0, 0);  // beyond the table, dropped
        push_word(CMD_DRAW, 0, 0);
        push_word(CMD_DRAW, 0, 16'hFFFF);
        push_word(CMD_DRAW, 0, 16'h8000);
        load_table(4, 1);           // all weights zero
        push_word(CMD_DRAW, 0, 16'h1234);
        drain();
        set_grid(0, 8191);          // clamps to 1 x 4096
        push_word(CMD_DRAW, 0, 0);
        drain();
        write_reg(REG_NARROW_RATIO, 24'h100);  // -256 acts as -255
        push_word(CMD_DRAW, 0, 0);
        push_word(CMD_DRAW, 0, 0);
        drain();
        write_reg(REG_NARROW_RATIO, 24'd255);
        set_grid(4096, 4096);       // bigger than the store
        push_word(CMD_LOAD, 0, 0);
        push_word(CMD_DRAW, 0, 0);
        drain();

        // Random phases over several grid and coordinate settings
        sent = 0;
        ph = 0;
        while (sent < 1750)
        begin
            idle_pct = (ph % 4 == 3) ? 0 : 28;
            gw = $urandom_range(1, 6);
            gh = $urandom_range(1, 6);
            if (ph % 7 == 6)
            begin
                gw = 97;
                gh = 3;
            end
            set_grid(gw, gh);
            r = $urandom_range(2) == 0 ? 0 : $urandom_range(255);
            if ($urandom_range(1)) r = -r;
            write_reg(REG_NARROW_RATIO, {15'd0, r[8:0]});
            write_reg(REG_ORIGIN_X, 24'($urandom));
            write_reg(REG_ORIGIN_Y, 24'($urandom));
            write_reg(REG_CELL_SIZE, ph % 5 == 0 ? 24'd1 : 24'($urandom_range(1, 65535)));
            load_table(gw * gh, $urandom_range(9) == 0 ? 1 : ($urandom_range(3) == 0 ? 2 : 0));
            sent += gw * gh + 1;
            for (int k = 0; k < 40; k++)
            begin
                case ($urandom_range(19))
                    0: push_word(CMD_LOAD, $urandom, $urandom);
                    1: push_word(2'd3, $urandom, $urandom);
                    default: push_word(CMD_DRAW, $urandom, $urandom);
                endcase
                sent++;
            end
            if ($urandom_range(5) == 0)
            begin
                push_word(CMD_RESTART, 0, 0);
                push_word(CMD_DRAW, 0, $urandom);
                sent += 2;
            end
            drain();
            ph++;
        end

        if (errors == 0)
            $display("weighted_grid_cell_sampler_test: done, clean");
        else
            $display("weighted_grid_cell_sampler_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/wgcs_pkg.sv
hw/rtl/wgcs_ram.sv
hw/rtl/wgcs_dp.sv
hw/rtl/wgcs_ctrl.sv
hw/rtl/weighted_grid_cell_sampler.sv
verif/weighted_grid_cell_sampler_test.sv
